FILE: hdl/ipwc_pkg.sv
package ipwc_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FALL  = 2'd1;
    localparam logic [1:0] OP_RISE  = 2'd2;
    localparam logic [1:0] OP_START = 2'd3;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [15:0] WORD_MAX    = 16'hFFFF;
    localparam logic [16:0] TIMEOUT_RST = 17'h1FFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic       pin_level;
        logic       tx_sending;
    } item_t;

    typedef struct packed {
        logic [15:0] raw_word;
        logic [16:0] duration_us;
        logic        is_mark;
    } result_t;

endpackage

FILE: hdl/ir_pulse_width_capture.sv
// Times mark and space pulses of an active-low infrared receiver from a stream of
// operations (microsecond tick, falling edge, rising edge, start) and emits one word per
// finished or timed-out pulse. One item is accepted every clock cycle while the output is not
// stalled; a result is presented behind an input register and a result register.
// The rate is set by the pulse state update, which is combinational between those registers.
// timeout_us is written on its own channel into a register that the pulse state update reads.
module ir_pulse_width_capture (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pin_level, tx_sending, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // raw_word, duration_us, zero pad
    output logic [0:0]  m_tuser,   // is_mark
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    logic              in_valid_reg, in_valid_next;
    ipwc_pkg::item_t   item_reg;
    logic [16:0]       timeout_reg;
    logic              out_free;
    logic              fire;
    logic              emit;
    ipwc_pkg::result_t result;
    ipwc_pkg::result_t out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ipwc_pkg::TIMEOUT_RST;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation  <= s_tuser;
            item_reg.pin_level  <= s_tdata[0];
            item_reg.tx_sending <= s_tdata[1];
        end
    end

    ipwc_pulse_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (item_reg),
        .timeout_us (timeout_reg),
        .emit       (emit),
        .result     (result)
    );

    ipwc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .emit     (emit),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .data     (out_data)
    );

    assign m_tdata = {7'd0, out_data.duration_us, out_data.raw_word};
    assign m_tuser = out_data.is_mark;

endmodule

FILE: hdl/ipwc_pulse_timer.sv
module ipwc_pulse_timer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ipwc_pkg::item_t   item,
    input  logic [16:0]       timeout_us,
    output logic              emit,
    output ipwc_pkg::result_t result
);

    logic        pulse_is_mark_reg, pulse_is_mark_next;
    logic [16:0] elapsed_us_reg, elapsed_us_next;
    logic        timed_out_reg, timed_out_next;

    logic [16:0] tick_count;
    logic [16:0] word_src;
    logic        word_mark;
    logic [17:0] rounded;
    logic [15:0] sat_word;

    assign tick_count = (elapsed_us_reg == ipwc_pkg::ELAPSED_MAX) ?
                        elapsed_us_reg : elapsed_us_reg + 17'd1;

    always_comb begin
        pulse_is_mark_next = pulse_is_mark_reg;
        elapsed_us_next    = elapsed_us_reg;
        timed_out_next     = timed_out_reg;
        emit               = 1'b0;
        word_src           = elapsed_us_reg;
        word_mark          = pulse_is_mark_reg;
        unique case (item.operation)
            ipwc_pkg::OP_TICK: begin
                elapsed_us_next = tick_count;
                word_src        = tick_count;
                if (!timed_out_reg && tick_count >= timeout_us) begin
                    emit           = 1'b1;
                    timed_out_next = 1'b1;
                end
            end
            ipwc_pkg::OP_FALL: begin
                if (!item.tx_sending && !pulse_is_mark_reg) begin
                    emit               = !timed_out_reg;
                    word_mark          = 1'b0;
                    pulse_is_mark_next = 1'b1;
                    elapsed_us_next    = '0;
                    timed_out_next     = 1'b0;
                end
            end
            ipwc_pkg::OP_RISE: begin
                if (pulse_is_mark_reg) begin
                    emit               = !timed_out_reg;
                    word_mark          = 1'b1;
                    pulse_is_mark_next = 1'b0;
                    elapsed_us_next    = '0;
                    timed_out_next     = 1'b0;
                end
            end
            default: begin
                pulse_is_mark_next = !item.pin_level;
                elapsed_us_next    = '0;
                timed_out_next     = 1'b0;
            end
        endcase
    end

    // round to 4 us in 2 us units, saturate, then mark flag in bit 0
    assign rounded  = ({1'b0, word_src} + 18'd2) >> 1;
    assign sat_word = (rounded[17:16] != 2'b00) ? ipwc_pkg::WORD_MAX : rounded[15:0];

    assign result.raw_word    = {sat_word[15:1], word_mark};
    assign result.duration_us = {sat_word[15:1], 2'b00};
    assign result.is_mark     = word_mark;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_is_mark_reg <= 1'b0;
            elapsed_us_reg    <= '0;
            timed_out_reg     <= 1'b0;
        end else if (fire) begin
            pulse_is_mark_reg <= pulse_is_mark_next;
            elapsed_us_reg    <= elapsed_us_next;
            timed_out_reg     <= timed_out_next;
        end
    end

endmodule

FILE: hdl/ipwc_out_reg.sv
module ipwc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              emit,
    input  ipwc_pkg::result_t result,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ipwc_pkg::result_t data
);

    logic              out_valid_reg, out_valid_next;
    ipwc_pkg::result_t data_reg;

    assign free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && emit) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign data     = data_reg;

endmodule
